FILE: hdl/line_window_clipper_defines.svh
// Assertion macros for the line window clipper.
`ifndef LINE_WINDOW_CLIPPER_DEFINES_SVH
`define LINE_WINDOW_CLIPPER_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define LWC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked on every rising edge outside reset.
`define LWC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/lwc_pkg.sv
// ----------------------------------------------------------------------------
// lwc_pkg
// Shared types and constants of the line window clipper.
// ----------------------------------------------------------------------------
package lwc_pkg;

    localparam int CoordW = 16;
    localparam int WinW = 15;
    localparam int DiffW = 17;
    localparam int ProdW = 32;
    localparam int MaxClips = 4;
    localparam int QueueDepthDefault = 2;

    localparam logic [3:0] CodeLeft = 4'd1;
    localparam logic [3:0] CodeRight = 4'd2;
    localparam logic [3:0] CodeTop = 4'd4;
    localparam logic [3:0] CodeBottom = 4'd8;

    localparam logic [WinW-1:0] MaxXReset = 15'd319;
    localparam logic [WinW-1:0] MaxYReset = 15'd199;

    localparam logic [0:0] RegMaxX = 1'b0;
    localparam logic [0:0] RegMaxY = 1'b1;

    typedef struct packed {
        logic signed [CoordW-1:0] x1;
        logic signed [CoordW-1:0] y1;
        logic signed [CoordW-1:0] x2;
        logic signed [CoordW-1:0] y2;
        logic [3:0] c1;
        logic [3:0] c2;
    } seg_t;

    typedef struct packed {
        logic visible;
        logic signed [CoordW-1:0] x1;
        logic signed [CoordW-1:0] y1;
        logic signed [CoordW-1:0] x2;
        logic signed [CoordW-1:0] y2;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_APPLY,
        ST_OUT
    } clip_state_t;

    function automatic logic [3:0] outcode(input logic signed [CoordW-1:0] x,
                                           input logic signed [CoordW-1:0] y,
                                           input logic [WinW-1:0] mx,
                                           input logic [WinW-1:0] my);
        logic [3:0] c;
        c = 4'd0;
        if (x < 0)
            c = c | CodeLeft;
        else if (x > $signed({1'b0, mx}))
            c = c | CodeRight;
        if (y < 0)
            c = c | CodeTop;
        else if (y > $signed({1'b0, my}))
            c = c | CodeBottom;
        return c;
    endfunction

endpackage

FILE: hdl/line_window_clipper.sv
// ----------------------------------------------------------------------------
// line_window_clipper
// Cohen-Sutherland clipper of one 16-bit segment to a programmable window.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Contents
// input     in         push / full         start_x start_y end_x end_y
// result    out        pop / empty         visible clip_* endpoints
// config    in         APB psel/penable    window_max_x @0, window_max_y @4
//
// Each clipping round uses the 32-step serial divider; a segment takes up
// to four rounds.
// A two-entry queue lets new segments enter while one is clipped.
// Reset is asynchronous; it clears the queue and the sequencer and sets the window to 319 by 199.
// The result waits in its register until popped.
// ----------------------------------------------------------------------------
`include "line_window_clipper_defines.svh"

module line_window_clipper
    import lwc_pkg::*;
#(
    parameter int QueueDepth = QueueDepthDefault
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic signed [CoordW-1:0] start_x,
    input  logic signed [CoordW-1:0] start_y,
    input  logic signed [CoordW-1:0] end_x,
    input  logic signed [CoordW-1:0] end_y,
    output logic                     empty,
    input  logic                     pop,
    output logic                     visible,
    output logic signed [CoordW-1:0] clip_start_x,
    output logic signed [CoordW-1:0] clip_start_y,
    output logic signed [CoordW-1:0] clip_end_x,
    output logic signed [CoordW-1:0] clip_end_y,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [WinW-1:0] max_x_reg;
    logic [WinW-1:0] max_y_reg;
    logic            seg_valid;
    logic            seg_take;
    seg_t            seg;
    logic            res_valid;
    res_t            res;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign prdata = (paddr[2] == RegMaxY) ? {17'd0, max_y_reg} : {17'd0, max_x_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= MaxXReset;
            max_y_reg <= MaxYReset;
        end
        else if (wr_en && paddr[1:0] == 2'd0)
        begin
            if (paddr[2] == RegMaxX)
                max_x_reg <= pwdata[WinW-1:0];
            else
                max_y_reg <= pwdata[WinW-1:0];
        end
    end

    lwc_front #(.Depth(QueueDepth)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .max_x     (max_x_reg),
        .max_y     (max_y_reg),
        .seg_valid (seg_valid),
        .seg       (seg),
        .seg_take  (seg_take)
    );

    lwc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg       (seg),
        .seg_take  (seg_take),
        .max_x     (max_x_reg),
        .max_y     (max_y_reg),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (pop)
    );

    assign empty = !res_valid;
    assign visible = res.visible;
    assign clip_start_x = res.x1;
    assign clip_start_y = res.y1;
    assign clip_end_x = res.x2;
    assign clip_end_y = res.y2;

    `LWC_ASSERT_IMP(a_reject_zero, !empty && !visible,
        clip_start_x == '0 && clip_start_y == '0 && clip_end_x == '0 && clip_end_y == '0)
    `LWC_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(visible))
    `LWC_ASSERT_IMP(a_take_when_valid, seg_take, seg_valid)

endmodule

FILE: hdl/lwc_front.sv
// ----------------------------------------------------------------------------
// lwc_front
// Accepts segments, computes outcodes and holds them in a short queue.
// ----------------------------------------------------------------------------
module lwc_front
    import lwc_pkg::*;
#(
    parameter int Depth = QueueDepthDefault
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic signed [CoordW-1:0] start_x,
    input  logic signed [CoordW-1:0] start_y,
    input  logic signed [CoordW-1:0] end_x,
    input  logic signed [CoordW-1:0] end_y,
    input  logic [WinW-1:0]          max_x,
    input  logic [WinW-1:0]          max_y,
    output logic                     seg_valid,
    output seg_t                     seg,
    input  logic                     seg_take
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

    seg_t                 mem_reg [Depth];
    logic [PtrW-1:0]      wr_ptr_reg;
    logic [PtrW-1:0]      wr_ptr_next;
    logic [PtrW-1:0]      rd_ptr_reg;
    logic [PtrW-1:0]      rd_ptr_next;
    logic [$clog2(Depth+1)-1:0] count_reg;
    logic [$clog2(Depth+1)-1:0] count_next;
    seg_t                 new_seg;
    logic                 do_push;
    logic                 do_pop;

    assign full = (count_reg == Depth[$clog2(Depth+1)-1:0]);
    assign seg_valid = (count_reg != '0);
    assign seg = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = seg_take && seg_valid;

    always_comb
    begin
        new_seg.x1 = start_x;
        new_seg.y1 = start_y;
        new_seg.x2 = end_x;
        new_seg.y2 = end_y;
        new_seg.c1 = outcode(start_x, start_y, max_x, max_y);
        new_seg.c2 = outcode(end_x, end_y, max_x, max_y);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= new_seg;
    end

endmodule

FILE: hdl/lwc_div.sv
// ----------------------------------------------------------------------------
// lwc_div
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module lwc_div
    import lwc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ProdW-1:0] dividend,
    input  logic signed [DiffW-1:0] divisor,
    output logic                    done,
    output logic signed [ProdW-1:0] quotient
);

    localparam int CntW = $clog2(ProdW + 1);

    logic [ProdW-1:0] num_reg;
    logic [ProdW-1:0] quo_reg;
    logic [DiffW:0]   rem_reg;
    logic [DiffW-1:0] den_reg;
    logic             neg_reg;
    logic             zero_reg;
    logic [CntW-1:0]  cnt_reg;
    logic             busy_reg;
    logic [DiffW:0]   trial;
    logic [DiffW:0]   shifted;

    assign shifted = {rem_reg[DiffW-1:0], num_reg[ProdW-1]};
    assign trial = shifted - {1'b0, den_reg};
    assign done = !busy_reg && !start;
    assign quotient = zero_reg ? '0 : (neg_reg ? -$signed(quo_reg) : $signed(quo_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= CntW'(ProdW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend[ProdW-1] ? ProdW'(-dividend) : ProdW'(dividend);
            den_reg <= divisor[DiffW-1] ? DiffW'(-divisor) : DiffW'(divisor);
            neg_reg <= dividend[ProdW-1] ^ divisor[DiffW-1];
            zero_reg <= (divisor == '0);
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[ProdW-2:0], 1'b0};
            if (!trial[DiffW])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[ProdW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[ProdW-2:0], 1'b0};
            end
        end
    end

endmodule

FILE: hdl/lwc_back.sv
// ----------------------------------------------------------------------------
// lwc_back
// Runs the clipping rounds of one segment and holds its result.
// ----------------------------------------------------------------------------
module lwc_back
    import lwc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            seg_valid,
    input  seg_t            seg,
    output logic            seg_take,
    input  logic [WinW-1:0] max_x,
    input  logic [WinW-1:0] max_y,
    output logic            res_valid,
    output res_t            res,
    input  logic            res_take
);

    clip_state_t              state_reg;
    clip_state_t              state_next;
    seg_t                     cur_reg;
    res_t                     res_reg;
    logic [2:0]               round_reg;
    logic signed [DiffW-1:0]  da_reg;
    logic signed [DiffW-1:0]  dn_reg;
    logic signed [DiffW-1:0]  dd_reg;
    logic signed [CoordW-1:0] base_reg;
    logic signed [CoordW-1:0] edge_reg;
    logic                     horiz_reg;
    logic [3:0]               oc;
    logic                     accept_now;
    logic                     reject_now;
    logic                     div_start;
    logic                     div_done;
    logic signed [ProdW-1:0]  quo;
    logic signed [CoordW-1:0] newc;
    logic signed [CoordW-1:0] nx;
    logic signed [CoordW-1:0] ny;
    logic signed [2*DiffW-1:0] full_prod;

    assign oc = (cur_reg.c1 != 4'd0) ? cur_reg.c1 : cur_reg.c2;
    assign accept_now = ((cur_reg.c1 | cur_reg.c2) == 4'd0);
    assign reject_now = ((cur_reg.c1 & cur_reg.c2) != 4'd0) ||
                        (round_reg == 3'(MaxClips));
    assign full_prod = da_reg * dn_reg;
    assign newc = base_reg + CoordW'(quo);
    assign nx = horiz_reg ? newc : edge_reg;
    assign ny = horiz_reg ? edge_reg : newc;
    assign res_valid = (state_reg == ST_OUT);
    assign res = res_reg;

    lwc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ProdW'(full_prod)),
        .divisor  (dd_reg),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (seg_valid) state_next = ST_EVAL;
            ST_EVAL:  if (accept_now || reject_now) state_next = ST_OUT;
                      else state_next = ST_MUL;
            ST_MUL:   state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_APPLY;
            ST_APPLY: state_next = ST_EVAL;
            ST_OUT:   if (res_take) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        seg_take = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE: seg_take = seg_valid;
            ST_MUL:  div_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cur_reg <= seg;
                round_reg <= '0;
            end
            ST_EVAL:
            begin
                if (accept_now)
                    res_reg <= {1'b1, cur_reg.x1, cur_reg.y1, cur_reg.x2, cur_reg.y2};
                else if (reject_now)
                    res_reg <= '0;
                else if ((oc & (CodeBottom | CodeTop)) != 4'd0)
                begin
                    horiz_reg <= 1'b1;
                    base_reg <= cur_reg.x1;
                    da_reg <= DiffW'(cur_reg.x2) - DiffW'(cur_reg.x1);
                    dd_reg <= DiffW'(cur_reg.y2) - DiffW'(cur_reg.y1);
                    if ((oc & CodeBottom) != 4'd0)
                    begin
                        edge_reg <= $signed({1'b0, max_y});
                        dn_reg <= $signed({2'b0, max_y}) - DiffW'(cur_reg.y1);
                    end
                    else
                    begin
                        edge_reg <= '0;
                        dn_reg <= -DiffW'(cur_reg.y1);
                    end
                end
                else
                begin
                    horiz_reg <= 1'b0;
                    base_reg <= cur_reg.y1;
                    da_reg <= DiffW'(cur_reg.y2) - DiffW'(cur_reg.y1);
                    dd_reg <= DiffW'(cur_reg.x2) - DiffW'(cur_reg.x1);
                    if ((oc & CodeRight) != 4'd0)
                    begin
                        edge_reg <= $signed({1'b0, max_x});
                        dn_reg <= $signed({2'b0, max_x}) - DiffW'(cur_reg.x1);
                    end
                    else
                    begin
                        edge_reg <= '0;
                        dn_reg <= -DiffW'(cur_reg.x1);
                    end
                end
            end
            ST_MUL: ;
            ST_DIV: ;
            ST_APPLY:
            begin
                round_reg <= round_reg + 1'b1;
                if (cur_reg.c1 != 4'd0)
                begin
                    cur_reg.x1 <= nx;
                    cur_reg.y1 <= ny;
                    cur_reg.c1 <= outcode(nx, ny, max_x, max_y);
                end
                else
                begin
                    cur_reg.x2 <= nx;
                    cur_reg.y2 <= ny;
                    cur_reg.c2 <= outcode(nx, ny, max_x, max_y);
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the line window clipper: random and corner segments
// are clipped by a behavioral predictor and the block's results are compared
// field by field in order, across several window settings.
// ----------------------------------------------------------------------------
module tb;
    import lwc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 1000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic signed [CoordW-1:0] start_x = '0;
    logic signed [CoordW-1:0] start_y = '0;
    logic signed [CoordW-1:0] end_x = '0;
    logic signed [CoordW-1:0] end_y = '0;
    logic empty;
    logic pop = 1'b0;
    logic visible;
    logic signed [CoordW-1:0] clip_start_x;
    logic signed [CoordW-1:0] clip_start_y;
    logic signed [CoordW-1:0] clip_end_x;
    logic signed [CoordW-1:0] clip_end_y;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    res_t clipped_q[$];
    logic [WinW-1:0] win_x = MaxXReset;
    logic [WinW-1:0] win_y = MaxYReset;
    int errors = 0;
    int cycles = 0;
    int burst_left = 0;

    line_window_clipper i_dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("line_window_clipper: mismatch");
            $finish;
        end
    end

    function automatic logic [3:0] region(int x, int y);
        logic [3:0] c;
        c = 4'd0;
        if (x < 0)
            c = c | CodeLeft;
        else if (x > int'(win_x))
            c = c | CodeRight;
        if (y < 0)
            c = c | CodeTop;
        else if (y > int'(win_y))
            c = c | CodeBottom;
        return c;
    endfunction

    function automatic int on_edge(int a, int da, int dn, int dd);
        longint p;
        longint q;
        logic [15:0] s;
        p = longint'(da) * longint'(dn);
        p = longint'($signed(p[31:0]));
        q = (dd == 0) ? 0 : p / dd;
        s = 16'(a + q);
        return int'($signed(s));
    endfunction

    function automatic res_t clip_segment(int x1, int y1, int x2, int y2);
        res_t r;
        logic [3:0] c1;
        logic [3:0] c2;
        logic [3:0] oc;
        int cx;
        int cy;
        int my;
        int mx;
        mx = int'(win_x);
        my = int'(win_y);
        r = '0;
        c1 = region(x1, y1);
        c2 = region(x2, y2);
        for (int rnd = 0; rnd <= MaxClips; rnd++)
        begin
            if ((c1 | c2) == 0)
            begin
                r.visible = 1'b1;
                r.x1 = 16'(x1);
                r.y1 = 16'(y1);
                r.x2 = 16'(x2);
                r.y2 = 16'(y2);
                break;
            end
            if ((c1 & c2) != 0 || rnd == MaxClips)
                break;
            oc = (c1 != 0) ? c1 : c2;
            if (oc & CodeBottom)
            begin
                cx = on_edge(x1, x2 - x1, my - y1, y2 - y1);
                cy = my;
            end
            else if (oc & CodeTop)
            begin
                cx = on_edge(x1, x2 - x1, -y1, y2 - y1);
                cy = 0;
            end
            else if (oc & CodeRight)
            begin
                cy = on_edge(y1, y2 - y1, mx - x1, x2 - x1);
                cx = mx;
            end
            else
            begin
                cy = on_edge(y1, y2 - y1, -x1, x2 - x1);
                cx = 0;
            end
            if (c1 != 0)
            begin
                x1 = cx;
                y1 = cy;
                c1 = region(x1, y1);
            end
            else
            begin
                x2 = cx;
                y2 = cy;
                c2 = region(x2, y2);
            end
        end
        return r;
    endfunction

    // Receiver stalls at random, and never stalls while bit 9 of the cycle counter is set.
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && pop && !empty)
        begin
            if (clipped_q.size() == 0)
            begin
                $display("%0t: unexpected result visible=%0d", $time, visible);
                errors++;
            end
            else
            begin
                e = clipped_q.pop_front();
                if (visible !== e.visible || clip_start_x !== e.x1 ||
                    clip_start_y !== e.y1 || clip_end_x !== e.x2 || clip_end_y !== e.y2)
                begin
                    $display("%0t: expected %0d %0d %0d %0d %0d, actual %0d %0d %0d %0d %0d",
                             $time, e.visible, e.x1, e.y1, e.x2, e.y2, visible,
                             clip_start_x, clip_start_y, clip_end_x, clip_end_y);
                    errors++;
                end
            end
        end
        if (cycles[9])
            pop <= 1'b1;
        else
            pop <= ($urandom_range(0, 3) != 0);
    end

    task automatic send_segment(int x1, int y1, int x2, int y2);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
            if (gap != 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        start_x <= 16'(x1);
        start_y <= 16'(y1);
        end_x <= 16'(x2);
        end_y <= 16'(y2);
        do
            @(posedge clk);
        while (full);
        clipped_q.push_back(clip_segment(int'($signed(16'(x1))), int'($signed(16'(y1))),
                                         int'($signed(16'(x2))), int'($signed(16'(y2)))));
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        push <= 1'b0;
        while (clipped_q.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
    endtask

    task automatic write_window(logic [WinW-1:0] mx, logic [WinW-1:0] my);
        for (int i = 0; i < 2; i++)
        begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= (i == 0) ? 3'(RegMaxX) << 2 : 3'(RegMaxY) << 2;
            pwdata <= (i == 0) ? 32'(mx) : 32'(my);
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        win_x = mx;
        win_y = my;
        @(posedge clk);
    endtask

    function automatic int near_coord(int m);
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 65535) - 32768;
            1: return m + $urandom_range(0, 8) - 4;
            2: return $urandom_range(0, 8) - 4;
            default: return $urandom_range(0, 2 * m + 20) - m / 2 - 10;
        endcase
    endfunction

    task automatic test_corners();
        int mx;
        int my;
        mx = int'(win_x);
        my = int'(win_y);
        send_segment(10, 10, 20, 20);
        send_segment(-5, -5, -10, -20);
        send_segment(mx + 5, 3, mx + 9, 7);
        send_segment(-50, my / 2, mx + 50, my / 2);
        send_segment(mx / 2, -50, mx / 2, my + 50);
        send_segment(-32768, -32768, 32767, 32767);
        send_segment(32767, -32768, -32768, 32767);
        send_segment(-32768, 5, 32767, 6);
        send_segment(0, 0, mx, my);
        send_segment(-1, my + 1, mx + 1, -1);
        send_segment(-10, 0, 0, -10);
        send_segment(-100, 50, 40, -300);
        send_segment(mx + 100, my + 100, -100, -100);
        send_segment(32767, 32767, 32767, -32768);
        send_segment(-30000, 20000, 30000, -25000);
        send_segment(5, my + 30000, 6, -30000);
    endtask

    task automatic test_random(int n);
        int mx;
        int my;
        mx = int'(win_x);
        my = int'(win_y);
        repeat (n)
            send_segment(near_coord(mx), near_coord(my), near_coord(mx), near_coord(my));
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corners();
        test_random(150);
        drain();
        write_window(15'd0, 15'd0);
        test_corners();
        test_random(80);
        drain();
        write_window(15'd32767, 15'd32767);
        test_corners();
        test_random(120);
        drain();
        write_window(15'(100 + $urandom_range(0, 3000)), 15'(50 + $urandom_range(0, 3000)));
        test_random(180);
        drain();
        write_window(15'd32767, 15'd0);
        test_random(60);
        drain();
        write_window(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)));
        test_random(110);
        drain();
        if (errors == 0 && clipped_q.size() == 0)
            $display("line_window_clipper: match");
        else
            $display("line_window_clipper: mismatch");
        $finish;
    end
endmodule
